>>> hw/rtl/b64sc_pkg.sv
`timescale 1ns / 1ps
package b64sc_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_NL  = 8'h0A;  // '\n'

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One request from the front: up to four output bytes, in order.
  typedef struct packed {
    logic [3:0][7:0] data;   // data[0] goes out first
    logic [2:0]      count;  // bytes to send, 0 means a bare end marker
    logic            nl;     // encoded text: subject to line breaking
    logic            last;
  } cmd_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)      enc_char = 8'd65 + w;
    else if (v < 6'd52) enc_char = 8'd71 + w;   // 'a' - 26
    else if (v < 6'd62) enc_char = w - 8'd4;    // '0' - 52
    else if (v == 6'd62) enc_char = 8'h2B;
    else                 enc_char = 8'h2F;
  endfunction

  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [7:0] w;
    w = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A)      w = c - 8'd65;
    else if (c >= 8'h61 && c <= 8'h7A) w = c - 8'd71;
    else if (c >= 8'h30 && c <= 8'h39) w = c + 8'd4;
    else if (c == 8'h2B)               w = 8'd62;
    else if (c == 8'h2F)               w = 8'd63;
    dec_value = w[5:0];
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

>>> hw/rtl/base64_stream_codec.sv
`timescale 1ns / 1ps
// A request goes through the request queue into the output register, from which it is popped.
// Throughput: one input byte per cycle while the request queue has room; the result
// port sends one byte per cycle while pop is held, so encode sends four characters,
// and at times a newline, per three input bytes.
// Reset (rst, synchronous, active high) clears the mode, the group and line state,
// the request queue and empties the output register; no clearing pass is needed.
module base64_stream_codec
  import b64sc_pkg::*;
#(
  parameter int LINE_CHARS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  cmd_t cmd, head;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  b64sc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .cmd       (cmd)
  );

  b64sc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_cmd (cmd),
    .rd     (q_pop),
    .head   (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64sc_back #(
    .LINE_CHARS (LINE_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

endmodule

>>> hw/rtl/b64sc_front.sv
`timescale 1ns / 1ps
module b64sc_front
  import b64sc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_data,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       cmd
);

  logic        decode_mode;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [1:0]  pad_count, pad_count_next;

  logic        accept;
  logic [23:0] gb, bits;
  logic [2:0]  cnt;
  logic [5:0]  v;
  logic [1:0]  pad_n;
  logic [1:0]  nb;

  assign accept = push && !q_full;

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    cmd       = '0;
    cmd.last  = in_last;
    gb        = '0;
    bits      = '0;
    cnt       = {1'b0, group_count} + 3'd1;
    v         = '0;
    pad_n     = pad_count;
    nb        = '0;
    if (!decode_mode) begin
      cmd.nl = 1'b1;
      gb = {group_bits[15:0], in_byte};
      if (cnt >= 3'd3) begin
        for (int i = 0; i < 4; i++) cmd.data[i] = enc_char(gb[23-6*i -: 6]);
        cmd.count        = 3'd4;
        group_bits_next  = '0;
        group_count_next = '0;
      end else if (in_last) begin
        bits = (cnt == 3'd1) ? {gb[7:0], 16'd0} : {gb[15:0], 8'd0};
        for (int i = 0; i < 4; i++)
          cmd.data[i] = (3'(i) <= cnt) ? enc_char(bits[23-6*i -: 6]) : CHAR_PAD;
        cmd.count = 3'd4;
      end else begin
        group_bits_next  = gb;
        group_count_next = cnt[1:0];
      end
    end else if (!is_space(in_byte)) begin
      if (in_byte == CHAR_PAD) begin
        if (pad_count != 2'd3) pad_n = pad_count + 2'd1;
      end else begin
        v = dec_value(in_byte);
      end
      gb = {group_bits[17:0], v};
      if (cnt == 3'd4) begin
        nb = 2'd3 - pad_n;
        cmd.data[0] = gb[23:16];
        cmd.data[1] = gb[15:8];
        cmd.data[2] = gb[7:0];
        cmd.count   = {1'b0, nb};
        group_bits_next  = '0;
        group_count_next = '0;
        pad_count_next   = '0;
      end else begin
        group_bits_next  = gb;
        group_count_next = cnt[1:0];
        pad_count_next   = pad_n;
      end
    end
    if (in_last) begin
      group_bits_next  = '0;
      group_count_next = '0;
      pad_count_next   = '0;
    end
  end

  assign q_push = accept && (in_last || cmd.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
      group_bits  <= '0;
      group_count <= '0;
      pad_count   <= '0;
    end else begin
      if (cfg_valid) decode_mode <= cfg_data;
      if (accept) begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        pad_count   <= pad_count_next;
      end
    end
  end

endmodule

>>> hw/rtl/b64sc_queue.sv
`timescale 1ns / 1ps
module b64sc_queue
  import b64sc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_cmd,
  input  logic rd,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t           mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0]   used;

  assign full  = (used == (QAW+1)'(QDEPTH));
  assign empty = (used == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (wr && !full) wptr <= wptr + 1'b1;
      if (rd && !empty) rptr <= rptr + 1'b1;
      used <= used + (QAW+1)'(wr && !full) - (QAW+1)'(rd && !empty);
    end
  end

  // the front stalls on full, so a write into a full queue means a lost request
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr && full))
    else $error("request written into full queue");

endmodule

>>> hw/rtl/b64sc_back.sv
`timescale 1ns / 1ps
module b64sc_back
  import b64sc_pkg::*;
#(
  parameter int LINE_CHARS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last
);

  localparam int LW = $clog2(LINE_CHARS);

  logic [LW-1:0] line;
  logic [LW:0]   lcnt;
  logic [1:0]    p;
  logic          nl_pending;
  logic          have;
  logic          load, final_byte, wrap;

  assign load       = !q_empty && (!have || pop);
  assign final_byte = (({1'b0, p} + 3'd1) == head.count);
  assign lcnt       = {1'b0, line} + (LW+1)'(1);
  assign wrap       = head.nl && (lcnt >= (LW+1)'(LINE_CHARS));
  assign empty      = !have;

  always_comb begin
    q_pop = 1'b0;
    if (load) begin
      if (head.count == 3'd0)     q_pop = 1'b1;
      else if (nl_pending)        q_pop = final_byte;
      else                        q_pop = final_byte && !wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.count == 3'd0) begin
        out_byte  <= 8'd0;
        out_valid <= 1'b0;
        out_last  <= 1'b1;
      end else if (nl_pending) begin
        out_byte  <= CHAR_NL;
        out_valid <= 1'b1;
        out_last  <= head.last && final_byte;
      end else begin
        out_byte  <= head.data[p];
        out_valid <= 1'b1;
        out_last  <= head.last && final_byte && !wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have       <= 1'b0;
      line       <= '0;
      p          <= '0;
      nl_pending <= 1'b0;
    end else begin
      if (load)     have <= 1'b1;
      else if (pop) have <= 1'b0;
      if (q_pop && head.last) begin
        line <= '0;
      end else if (load && head.count != 3'd0 && !nl_pending && head.nl) begin
        line <= wrap ? '0 : lcnt[LW-1:0];
      end
      if (load && head.count != 3'd0) begin
        if (nl_pending) begin
          nl_pending <= 1'b0;
        end else begin
          nl_pending <= wrap;
        end
        if (!nl_pending && !wrap && !final_byte) p <= p + 2'd1;
        else if (!nl_pending && wrap)            p <= p;
        else if (!final_byte)                    p <= p + 2'd1;
        else                                     p <= '0;
      end
    end
  end

  a_nl_owner: assert property (@(posedge clk) disable iff (rst)
    nl_pending |-> (!q_empty && head.nl))
    else $error("newline pending without an encode request");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (have && !out_valid) |-> out_last)
    else $error("bare end marker not flagged last");

  a_line_clear: assert property (@(posedge clk) disable iff (rst)
    (q_pop && head.last) |=> (line == '0 && p == '0 && !nl_pending))
    else $error("line state not cleared at message end");

endmodule
